// File: src/mgnm_pkg.sv
// Package for the multi-glob name matcher: character codes, item and op codes,
// the op struct passed from front to back, and the case-fold function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mgnm_pkg;

  localparam int PATTERN_BYTES_DEF = 128;

  localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
  localparam logic [7:0] CH_QMARK = 8'h3F;  // '?'
  localparam logic [7:0] CH_PIPE  = 8'h7C;  // '|'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_UPA   = 8'h41;  // 'A'
  localparam logic [7:0] CH_UPZ   = 8'h5A;  // 'Z'
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic FUNC_LIST = 1'b0;
  localparam logic FUNC_NAME = 1'b1;

  // One op per accepted transaction; index fields travel next to it.
  typedef struct packed {
    logic       wr_en;      // write one pattern cell
    logic       wr_first;
    logic       wr_final;
    logic       fin_en;     // mark an earlier cell as token end
    logic       commit;     // list closed: take new length and match-all
    logic       match_all;
    logic       match_en;   // filename item
    logic       consume;    // filename item carries a byte
    logic       last;
    logic [7:0] ch;
  } op_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= CH_UPA && c <= CH_UPZ) begin
      return c + CASE_OFS;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: src/mgnm_fifo.sv
// Two-entry queue between the front classifier and the back matcher.
// Generic payload width; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module mgnm_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  not_full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      pop_data
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;

  assign not_full  = (cnt_r != 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end
endmodule
`default_nettype wire

// File: src/mgnm_front.sv
// Front end: parses glob list bytes into token cells (trim, skip separators,
// collapse star runs) and turns every transaction into one op. Uses mgnm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mgnm_front #(
  parameter int PATTERN_BYTES = mgnm_pkg::PATTERN_BYTES_DEF,
  parameter int IW = $clog2(PATTERN_BYTES),
  parameter int LW = $clog2(PATTERN_BYTES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire logic          func,
  input  wire logic [7:0]    char_byte,
  input  wire logic          no_char,
  input  wire logic          last,
  output mgnm_pkg::op_t      op,
  output logic [IW-1:0]      wr_idx,
  output logic [IW-1:0]      fin_idx,
  output logic [LW-1:0]      new_len
);
  import mgnm_pkg::*;

  logic          loading_r, loading_nxt;
  logic [LW-1:0] raw_r, raw_nxt;
  logic [LW-1:0] w_r, w_nxt;
  logic          in_tok_r, in_tok_nxt;
  logic          prev_star_r, prev_star_nxt;
  logic [IW-1:0] lastc_r, lastc_nxt;
  logic          b0star_r, b0star_nxt;

  always_comb begin
    logic is_sep;
    logic is_star;
    logic wrote_ch;
    is_sep  = (char_byte == CH_PIPE) || (char_byte == CH_COMMA) || (char_byte == CH_SEMI);
    is_star = (char_byte == CH_STAR);
    wrote_ch = 1'b0;

    loading_nxt   = loading_r;
    raw_nxt       = raw_r;
    w_nxt         = w_r;
    in_tok_nxt    = in_tok_r;
    prev_star_nxt = prev_star_r;
    lastc_nxt     = lastc_r;
    b0star_nxt    = b0star_r;

    op       = '0;
    op.ch    = char_byte;
    op.last  = last;
    wr_idx   = w_r[IW-1:0];
    fin_idx  = lastc_r;
    new_len  = w_r;

    if (func == FUNC_LIST) begin
      if (!loading_r) begin
        raw_nxt       = '0;
        w_nxt         = '0;
        in_tok_nxt    = 1'b0;
        prev_star_nxt = 1'b0;
        b0star_nxt    = 1'b0;
      end
      wr_idx = w_nxt[IW-1:0];
      if (!no_char && raw_nxt < LW'(PATTERN_BYTES)) begin
        if (raw_nxt == '0) b0star_nxt = is_star;
        raw_nxt = raw_nxt + LW'(1);
        if (is_sep) begin
          if (in_tok_nxt) begin
            op.fin_en = 1'b1;
            fin_idx   = lastc_nxt;
          end
          in_tok_nxt    = 1'b0;
          prev_star_nxt = 1'b0;
        end else if (char_byte == CH_SPACE) begin
          // leading spaces drop; inner/trailing ones are kept (trailing ones are inert)
          if (in_tok_nxt) begin
            op.wr_en      = 1'b1;
            w_nxt         = w_nxt + LW'(1);
            prev_star_nxt = 1'b0;
          end
        end else if (!(is_star && in_tok_nxt && prev_star_nxt)) begin
          op.wr_en      = 1'b1;
          op.wr_first   = !in_tok_nxt;
          wrote_ch      = 1'b1;
          lastc_nxt     = w_nxt[IW-1:0];
          w_nxt         = w_nxt + LW'(1);
          in_tok_nxt    = 1'b1;
          prev_star_nxt = is_star;
        end
      end
      if (last) begin
        op.commit    = 1'b1;
        new_len      = w_nxt;
        op.match_all = (raw_nxt == '0) || (raw_nxt == LW'(1) && b0star_nxt);
        if (wrote_ch) begin
          op.wr_final = 1'b1;
        end else if (in_tok_nxt) begin
          op.fin_en = 1'b1;
          fin_idx   = lastc_nxt;
        end
        loading_nxt = 1'b0;
      end else begin
        loading_nxt = 1'b1;
      end
    end else begin
      if (loading_r) begin
        op.commit    = 1'b1;
        op.match_all = (raw_r == '0) || (raw_r == LW'(1) && b0star_r);
        op.fin_en    = in_tok_r;
        loading_nxt  = 1'b0;
      end
      op.match_en = 1'b1;
      op.consume  = !no_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loading_r <= 1'b0;
    end else if (fire) begin
      loading_r <= loading_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      raw_r       <= raw_nxt;
      w_r         <= w_nxt;
      in_tok_r    <= in_tok_nxt;
      prev_star_r <= prev_star_nxt;
      lastc_r     <= lastc_nxt;
      b0star_r    <= b0star_nxt;
    end
  end
endmodule
`default_nettype wire

// File: src/mgnm_back.sv
// Back end: holds the pattern cells and the active-position vector, applies
// ops and registers the match result. Uses mgnm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mgnm_back #(
  parameter int PATTERN_BYTES = mgnm_pkg::PATTERN_BYTES_DEF,
  parameter int IW = $clog2(PATTERN_BYTES),
  parameter int LW = $clog2(PATTERN_BYTES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          op_valid,
  output logic               op_ready,
  input  mgnm_pkg::op_t      op,
  input  wire logic [IW-1:0] wr_idx,
  input  wire logic [IW-1:0] fin_idx,
  input  wire logic [LW-1:0] new_len,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_matched
);
  import mgnm_pkg::*;

  localparam int P = PATTERN_BYTES;

  logic [7:0]    cell_ch_r    [P];
  logic [P-1:0]  cell_first_r;
  logic [P-1:0]  cell_final_r;
  logic [LW-1:0] len_r;
  logic          match_all_r;
  logic          fresh_r;        // act_r stands for the restart vector
  logic [P:0]    act_r;
  logic          out_valid_r;
  logic          out_matched_r;

  logic          fire;
  logic [LW-1:0] len_eff;
  logic [P-1:0]  live, star, final_eff;
  logic [P:0]    rst_vec, base, pre, nv, after;
  logic          hit, matched;

  assign op_ready    = !out_valid_r || out_ready;
  assign fire        = op_valid && op_ready;
  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;
  assign len_eff     = op.commit ? new_len : len_r;

  always_comb begin
    rst_vec[0] = 1'b1;
    pre[0]     = 1'b0;
    nv[0]      = 1'b0;
    for (int i = 0; i < P; i++) begin
      live[i]      = (LW'(i) < len_eff);
      star[i]      = (cell_ch_r[i] == CH_STAR);
      rst_vec[i+1] = live[i] && star[i] && cell_first_r[i];
      final_eff[i] = cell_final_r[i] || (op.fin_en && fin_idx == IW'(i));
    end
    base = (fresh_r || op.commit) ? rst_vec : act_r;
    for (int i = 0; i < P; i++) begin
      pre[i+1] = live[i] && !star[i]
               && (cell_first_r[i] ? base[0] : base[i])
               && (cell_ch_r[i] == CH_QMARK
                   || fold_case(cell_ch_r[i]) == fold_case(op.ch));
    end
    // stars never follow stars inside a token, so closure is one step
    for (int i = 0; i < P; i++) begin
      nv[i+1] = star[i] ? (live[i] && (base[i+1] || (!cell_first_r[i] && pre[i])))
                        : pre[i+1];
    end
    after   = op.consume ? nv : base;
    hit     = |(final_eff & live & after[P:1]);
    matched = (op.commit ? op.match_all : match_all_r) || hit;
  end

  always_ff @(posedge clk) begin
    if (fire && op.wr_en) begin
      cell_ch_r[wr_idx]    <= op.ch;
      cell_first_r[wr_idx] <= op.wr_first;
    end
    if (fire && op.match_en && !op.last) begin
      act_r <= after;
    end
    if (fire) begin
      for (int i = 0; i < P; i++) begin
        if (op.fin_en && fin_idx == IW'(i)) begin
          cell_final_r[i] <= 1'b1;
        end else if (op.wr_en && wr_idx == IW'(i)) begin
          cell_final_r[i] <= op.wr_final;
        end
      end
    end
    if (fire && op.match_en && op.last) begin
      out_matched_r <= matched;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      match_all_r <= 1'b1;
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (fire && op.commit) begin
        len_r       <= new_len;
        match_all_r <= op.match_all;
      end
      if (fire && op.match_en) begin
        fresh_r <= op.last;
      end else if (fire && op.commit) begin
        fresh_r <= 1'b1;
      end
      if (fire && op.match_en && op.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: src/multi_glob_name_matcher_top.sv
// Top level of the multi-glob name matcher: front classifier, op queue, back matcher.
// Depends on mgnm_pkg, mgnm_front, mgnm_fifo, mgnm_back.
//
//  channel | ports                                          | dir
//  in      | in_valid in_ready in_func in_char_byte         | in
//          | in_no_char in_last                             |
//  out     | out_valid out_ready out_matched                | out
//
// One transaction per cycle sustained while the output is not stalled; a two-entry
// queue sits between the front and the back.
// A result lands in the back's output register once the op for the last filename
// byte has passed through the queue and the back is not held by a stalled output.
// Synchronous active-low reset; no clearing pass, cells are tracked by length.
// A stalled output holds the back; the queue keeps accepting input until it holds two ops.
`timescale 1ns / 1ps
`default_nettype none
module multi_glob_name_matcher_top #(
  parameter int PATTERN_BYTES = mgnm_pkg::PATTERN_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_func,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_no_char,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_matched
);
  import mgnm_pkg::*;

  localparam int IW = $clog2(PATTERN_BYTES);
  localparam int LW = $clog2(PATTERN_BYTES + 1);
  localparam int QW = $bits(op_t) + 2 * IW + LW;

  op_t           f_op, b_op;
  logic [IW-1:0] f_wr_idx, f_fin_idx, b_wr_idx, b_fin_idx;
  logic [LW-1:0] f_len, b_len;
  logic          in_fire, q_valid, q_pop, b_ready;

  assign in_fire = in_valid && in_ready;
  assign q_pop   = q_valid && b_ready;

  mgnm_front #(.PATTERN_BYTES(PATTERN_BYTES), .IW(IW), .LW(LW)) u_front (
    .clk(clk), .rst_n(rst_n), .fire(in_fire),
    .func(in_func), .char_byte(in_char_byte), .no_char(in_no_char), .last(in_last),
    .op(f_op), .wr_idx(f_wr_idx), .fin_idx(f_fin_idx), .new_len(f_len)
  );

  mgnm_fifo #(.WIDTH(QW)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(in_fire), .push_data({f_op, f_wr_idx, f_fin_idx, f_len}), .not_full(in_ready),
    .pop(q_pop), .not_empty(q_valid), .pop_data({b_op, b_wr_idx, b_fin_idx, b_len})
  );

  mgnm_back #(.PATTERN_BYTES(PATTERN_BYTES), .IW(IW), .LW(LW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .op_valid(q_valid), .op_ready(b_ready), .op(b_op),
    .wr_idx(b_wr_idx), .fin_idx(b_fin_idx), .new_len(b_len),
    .out_valid(out_valid), .out_ready(out_ready), .out_matched(out_matched)
  );

`ifndef ASSERT_OFF
  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && b_op.match_en && b_op.last) |=> out_valid)
    else $error("result missing after last filename op");

  a_list_ops_write_only: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && f_op.wr_en) |-> (in_func == FUNC_LIST && !f_op.match_en))
    else $error("cell write from a filename transaction");

  a_rise_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop && b_op.match_en && b_op.last))
    else $error("result without a last filename op");
`endif

endmodule
`default_nettype wire

// File: test/multi_glob_name_matcher_top_tb.sv
// Testbench for multi_glob_name_matcher_top: loads glob lists, streams filenames and
// checks each match verdict against a behavioral predictor. Depends on mgnm_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none

class match_scoreboard;
  logic [9:0] cells[128];
  int unsigned cell_count;
  bit everything;
  bit act[129];
  bit loading;
  bit verdicts[$];
  int errors;

  function new();
    cell_count = 0;
    everything = 1;
    loading = 0;
    errors = 0;
    restart();
  endfunction

  function bit is_sep(logic [7:0] c);
    return c == mgnm_pkg::CH_PIPE || c == mgnm_pkg::CH_COMMA || c == mgnm_pkg::CH_SEMI;
  endfunction

  function logic [7:0] lower(logic [7:0] c);
    return (c >= mgnm_pkg::CH_UPA && c <= mgnm_pkg::CH_UPZ) ? c + 8'h20 : c;
  endfunction

  function bit entry_active(int i);
    return cells[i][8] ? act[0] : act[i];
  endfunction

  function void pass_stars();
    for (int i = 0; i < cell_count; i++)
      if (cells[i][7:0] == mgnm_pkg::CH_STAR && entry_active(i)) act[i+1] = 1;
  endfunction

  function void restart();
    foreach (act[i]) act[i] = 0;
    act[0] = 1;
    pass_stars();
  endfunction

  function void close_list();
    int unsigned w, a, lo, hi;
    logic [9:0] v;
    w = 0;
    a = 0;
    everything = cell_count == 0 || (cell_count == 1 && cells[0][7:0] == mgnm_pkg::CH_STAR);
    for (int unsigned k = 0; k <= cell_count; k++) begin
      if (k < cell_count && !is_sep(cells[k][7:0])) continue;
      lo = a;
      hi = k;
      while (lo < hi && cells[lo][7:0] == mgnm_pkg::CH_SPACE) lo++;
      while (hi > lo && cells[hi-1][7:0] == mgnm_pkg::CH_SPACE) hi--;
      for (int unsigned j = lo; j < hi; j++) begin
        v = {2'b00, cells[j][7:0]};
        if (j == lo) v[8] = 1;
        if (j + 1 == hi) v[9] = 1;
        cells[w + j - lo] = v;
      end
      w += hi - lo;
      a = k + 1;
    end
    cell_count = w;
    loading = 0;
    restart();
  endfunction

  function void step_name(logic [7:0] c);
    bit nxt[129];
    logic [7:0] p;
    foreach (nxt[i]) nxt[i] = 0;
    for (int i = 0; i < cell_count; i++) begin
      p = cells[i][7:0];
      if (p == mgnm_pkg::CH_STAR) nxt[i+1] = act[i+1];
      else if (entry_active(i) && (p == mgnm_pkg::CH_QMARK || lower(p) == lower(c)))
        nxt[i+1] = 1;
    end
    act = nxt;
    act[0] = 0;
    pass_stars();
  endfunction

  function void note_input(logic func, logic [7:0] c, logic no_char, logic last);
    bit hit;
    if (func == mgnm_pkg::FUNC_LIST) begin
      if (!loading) begin
        loading = 1;
        cell_count = 0;
      end
      if (!no_char && cell_count < 128) begin
        cells[cell_count] = {2'b00, c};
        cell_count++;
      end
      if (last) close_list();
      return;
    end
    if (loading) close_list();
    if (!no_char) step_name(c);
    if (!last) return;
    hit = everything;
    for (int i = 0; i < cell_count; i++) if (cells[i][9] && act[i+1]) hit = 1;
    verdicts.push_back(hit);
    restart();
  endfunction

  task report(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  task check_result(logic matched);
    bit exp_hit;
    if (verdicts.size() == 0) begin
      report($sformatf("unexpected result matched=%0b", matched));
      return;
    end
    exp_hit = verdicts.pop_front();
    if (matched !== exp_hit) begin
      report($sformatf("matched=%0b, predicted %0b", matched, exp_hit));
    end
  endtask
endclass

module multi_glob_name_matcher_top_tb;
  import mgnm_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready, in_func, in_no_char, in_last;
  logic [7:0] in_char_byte;
  logic out_valid, out_ready, out_matched;

  match_scoreboard sb;
  int items_sent, results_seen, names_sent, idle_cycles;

  multi_glob_name_matcher_top uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_func, in_char_byte, in_no_char, in_last);
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_matched);
      results_seen++;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver side stalls
  initial begin
    int w;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      repeat (w) @(posedge clk);
      out_ready <= 1;
      @(posedge clk iff out_valid);
      if ($urandom_range(0, 1)) out_ready <= 0;
    end
  end

  bit no_gaps;

  task automatic send(logic func, logic [7:0] c, logic nc, logic last);
    int w;
    w = no_gaps ? 0 : $urandom_range(0, 6);
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1;
    in_func <= func;
    in_char_byte <= c;
    in_no_char <= nc;
    in_last <= last;
    @(posedge clk iff in_ready);
    items_sent++;
  endtask

  task automatic send_str(logic func, string s);
    if (s.len() == 0) send(func, 8'h00, 1, 1);
    for (int i = 0; i < s.len(); i++) send(func, s[i], 0, i == s.len() - 1);
    if (func == FUNC_NAME) names_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0: return CH_STAR;
      1: return CH_QMARK;
      2: return CH_SPACE;
      3: return CH_PIPE;
      4: return CH_COMMA;
      5: return CH_SEMI;
      6: return 8'($urandom_range(0, 255));
      7: return 8'($urandom_range(8'h41, 8'h44));
      default: return 8'($urandom_range(8'h61, 8'h64));
    endcase
  endfunction

  function automatic logic [7:0] name_char();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h44))
                                : 8'($urandom_range(8'h61, 8'h64));
  endfunction

  initial begin
    int n;
    sb = new();
    items_sent = 0;
    results_seen = 0;
    names_sent = 0;
    idle_cycles = 0;
    no_gaps = 0;
    rst_n = 0;
    in_valid = 0;
    in_func = 0;
    in_char_byte = 0;
    in_no_char = 0;
    in_last = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: match-all after reset, trimming, wildcards, case, odd items
    send_str(FUNC_NAME, "abc");
    send_str(FUNC_NAME, "");
    send_str(FUNC_LIST, "*");
    send_str(FUNC_NAME, "x");
    send_str(FUNC_LIST, " A?c ,, ;*.Txt| ");
    send_str(FUNC_NAME, "abc");
    send_str(FUNC_NAME, "FOO.txt");
    send_str(FUNC_NAME, "ab");
    send(FUNC_LIST, 8'h00, 0, 0);
    send(FUNC_LIST, 8'hff, 1, 0);
    send(FUNC_NAME, 8'h00, 0, 0);  // closes the load early
    send(FUNC_NAME, 8'h00, 1, 1);
    send_str(FUNC_LIST, "");
    send_str(FUNC_NAME, "q");
    drain();
    no_gaps = 1;
    for (int i = 0; i < 140; i++) send(FUNC_LIST, 8'h61, 0, i == 139);  // overflow
    send_str(FUNC_NAME, "aa");
    no_gaps = 0;
    drain();  // sender holds until every verdict is back

    // random: mostly short lists followed by a few names
    while (items_sent < 700 || names_sent < 60) begin
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++)
        send(FUNC_LIST, pick_char(), $urandom_range(0, 15) == 0, i == n - 1);
      if (n == 0 && $urandom_range(0, 1)) send(FUNC_LIST, 8'h00, 1, 1);
      repeat ($urandom_range(1, 4)) begin
        n = $urandom_range(0, 8);
        if (n == 0) send(FUNC_NAME, 8'($urandom), 1, 1);
        for (int i = 0; i < n; i++)
          send(FUNC_NAME, name_char(), $urandom_range(0, 15) == 0, i == n - 1);
        names_sent++;
      end
    end
    drain();
    repeat (10) @(posedge clk);

    $display("covered %0d items and %0d verdicts across list loads, wildcards,", items_sent,
             results_seen);
    $display("overflow, no-char items and early-closed loads");
    if (sb.errors == 0 && sb.verdicts.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

// File: multi_glob_name_matcher_top.f
src/mgnm_pkg.sv
src/mgnm_fifo.sv
src/mgnm_front.sv
src/mgnm_back.sv
src/multi_glob_name_matcher_top.sv
test/multi_glob_name_matcher_top_tb.sv
